/* rtl/core/pacb_pkg.sv */
// ----------------------------------------------------------------------------
// pacb_pkg
// Shared types and constants of the polygon area, centroid and bounds block.
// ----------------------------------------------------------------------------
`default_nettype none

package pacb_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_NORTH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOUTH = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EAST  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WEST  = 8'd3;

  localparam int ACC_W      = 64;
  localparam int LEN_ACC_W  = 48;
  localparam int MUL_CHUNK  = 16;
  localparam int SQRT_IN_W  = 66;
  localparam int SQRT_OUT_W = 33;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_EMPTY,
    OP_OPEN,
    OP_SEGMENT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic rev;
    logic ends;
  } item_ctrl_t;

  typedef struct packed {
    logic load_north;
    logic load_south;
    logic load_east;
    logic load_west;
  } cfg_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LOAD,
    ST_MUL,
    ST_MUL_DONE,
    ST_NORM,
    ST_SQRT,
    ST_FIN,
    ST_DIVX_LD,
    ST_DIVX,
    ST_DIVY_LD,
    ST_DIVY,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    JOB_AREA,
    JOB_A2,
    JOB_B2,
    JOB_WX,
    JOB_WY
  } job_e;

endpackage

`default_nettype wire

/* rtl/core/pacb_front.sv */
// ----------------------------------------------------------------------------
// pacb_front
// Accepts vertex items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pacb_front #(
  parameter int COORD_WIDTH = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire signed [COORD_WIDTH-1:0]  coord_x_i,
  input  wire signed [COORD_WIDTH-1:0]  coord_y_i,
  input  wire                           starts_line_i,
  input  wire                           line_reversed_i,
  input  wire                           ends_area_i,
  input  wire                           empty_area_i,
  output logic                          q_valid_o,
  input  wire                           q_pop_i,
  output logic signed [COORD_WIDTH-1:0] q_x_o,
  output logic signed [COORD_WIDTH-1:0] q_y_o,
  output pacb_pkg::item_ctrl_t          q_ctrl_o
);

  localparam int PW = $clog2(pacb_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(pacb_pkg::QUEUE_DEPTH + 1);

  logic signed [COORD_WIDTH-1:0] x_mem [pacb_pkg::QUEUE_DEPTH];
  logic signed [COORD_WIDTH-1:0] y_mem [pacb_pkg::QUEUE_DEPTH];
  pacb_pkg::item_ctrl_t          c_mem [pacb_pkg::QUEUE_DEPTH];

  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          have_prev_q;
  logic          push, pop;
  pacb_pkg::item_ctrl_t cls;

  assign in_ready_o = (cnt_q != CW'(pacb_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    cls.rev  = line_reversed_i;
    cls.ends = ends_area_i;
    if (empty_area_i) begin
      cls.op = pacb_pkg::OP_EMPTY;
    end else if (starts_line_i || !have_prev_q) begin
      cls.op = pacb_pkg::OP_OPEN;
    end else begin
      cls.op = pacb_pkg::OP_SEGMENT;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  assign q_x_o    = x_mem[rd_ptr_q];
  assign q_y_o    = y_mem[rd_ptr_q];
  assign q_ctrl_o = c_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      have_prev_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q    <= wr_ptr_q + PW'(1);
        have_prev_q <= !empty_area_i && !ends_area_i;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      x_mem[wr_ptr_q] <= coord_x_i;
      y_mem[wr_ptr_q] <= coord_y_i;
      c_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pacb_sqrt.sv */
// ----------------------------------------------------------------------------
// pacb_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pacb_sqrt (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start_i,
  input  wire [pacb_pkg::SQRT_IN_W-1:0]       radicand_i,
  output logic                                busy_o,
  output logic [pacb_pkg::SQRT_OUT_W-1:0]     root_o
);

  localparam int RN = pacb_pkg::SQRT_OUT_W;
  localparam int RM = RN + 3;
  localparam int CW = $clog2(RN + 1);

  logic                              busy_q;
  logic [CW-1:0]                     cnt_q;
  logic [pacb_pkg::SQRT_IN_W-1:0]    rad_q;
  logic [RM-1:0]                     rem_q;
  logic [RN-1:0]                     root_q;
  logic [RM-1:0]                     rem_t, trial;

  assign rem_t  = {rem_q[RM-3:0], rad_q[pacb_pkg::SQRT_IN_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign busy_o = busy_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(RN);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[RN-2:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[RN-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pacb_div.sv */
// ----------------------------------------------------------------------------
// pacb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pacb_div (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire [pacb_pkg::ACC_W-1:0]        dividend_i,
  input  wire [pacb_pkg::LEN_ACC_W-1:0]    divisor_i,
  output logic                             busy_o,
  output logic [pacb_pkg::ACC_W-1:0]       quotient_o
);

  localparam int QN = pacb_pkg::ACC_W;
  localparam int DN = pacb_pkg::LEN_ACC_W;
  localparam int CW = $clog2(QN + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [QN-1:0] quo_q;
  logic [DN-1:0] rem_q, dvs_q;
  logic [DN:0]   rem_t;

  assign rem_t      = {rem_q, quo_q[QN-1]};
  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QN);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (rem_t >= {1'b0, dvs_q}) begin
        rem_q <= DN'(rem_t - {1'b0, dvs_q});
        quo_q <= {quo_q[QN-2:0], 1'b1};
      end else begin
        rem_q <= rem_t[DN-1:0];
        quo_q <= {quo_q[QN-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pacb_back.sv */
// ----------------------------------------------------------------------------
// pacb_back
// Carries out queued items: segment terms, accumulation, bounds and result.
// ----------------------------------------------------------------------------
`default_nettype none

module pacb_back #(
  parameter int COORD_WIDTH = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              q_valid_i,
  output logic                             q_pop_o,
  input  wire signed [COORD_WIDTH-1:0]     q_x_i,
  input  wire signed [COORD_WIDTH-1:0]     q_y_i,
  input  pacb_pkg::item_ctrl_t             q_ctrl_i,
  input  pacb_pkg::cfg_ctrl_t              cfg_ctrl_i,
  input  wire signed [COORD_WIDTH-1:0]     cfg_wdata_i,
  input  wire signed [COORD_WIDTH-1:0]     init_north_i,
  input  wire signed [COORD_WIDTH-1:0]     init_south_i,
  input  wire signed [COORD_WIDTH-1:0]     init_east_i,
  input  wire signed [COORD_WIDTH-1:0]     init_west_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             status_o,
  output logic signed [63:0]               signed_area_o,
  output logic signed [COORD_WIDTH-1:0]    bound_north_o,
  output logic signed [COORD_WIDTH-1:0]    bound_south_o,
  output logic signed [COORD_WIDTH-1:0]    bound_east_o,
  output logic signed [COORD_WIDTH-1:0]    bound_west_o,
  output logic signed [COORD_WIDTH-1:0]    centroid_x_o,
  output logic signed [COORD_WIDTH-1:0]    centroid_y_o,
  output logic                             centroid_valid_o
);

  localparam int W     = COORD_WIDTH;
  localparam int DW    = W + 1;
  localparam int LEN_W = W + 3;
  localparam int CH    = pacb_pkg::MUL_CHUNK;
  localparam int NCH   = (DW + CH - 1) / CH;
  localparam int BPW   = NCH * CH;
  localparam int PW    = LEN_W + BPW;
  localparam int PX    = (PW > 65) ? PW : 65;
  localparam int ABW   = (DW > 33) ? DW : 33;
  localparam int KW    = $clog2(ABW);
  localparam int RW2   = (LEN_W > pacb_pkg::SQRT_OUT_W) ? LEN_W : pacb_pkg::SQRT_OUT_W;
  localparam int SUMW  = ((LEN_W > pacb_pkg::LEN_ACC_W) ? LEN_W : pacb_pkg::LEN_ACC_W) + 1;
  localparam int MCW   = $clog2(NCH + 1);
  localparam int AW    = pacb_pkg::ACC_W;

  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic signed [W-1:0]  C_MAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  C_MIN   = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                   input logic signed [AW-1:0] b);
    logic [AW:0] s;
    s = {a[AW-1], a} + {b[AW-1], b};
    if (s[AW] != s[AW-1]) begin
      return s[AW] ? ACC_MIN : ACC_MAX;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic signed [AW-1:0] half_term(input logic [PX-1:0] p, input logic neg);
    logic [AW-1:0] m;
    m = {1'b0, p[AW-1:1]};
    if (|p[PX-1:AW]) begin
      return neg ? ACC_MIN : ACC_MAX;
    end
    return neg ? -m : m;
  endfunction

  function automatic logic signed [W-1:0] clamp(input logic [AW-1:0] q, input logic neg);
    if (q > AW'(C_MAX)) begin
      return neg ? C_MIN : C_MAX;
    end
    return neg ? -W'(q) : W'(q);
  endfunction

  pacb_pkg::state_e state_q, state_d;
  pacb_pkg::job_e   job_q;
  logic             ends_q, res_empty_q;

  logic signed [W-1:0]  prev_x_q, prev_y_q;
  logic                 cur_rev_q, area_open_q;
  logic signed [AW-1:0] area_q, wx_q, wy_q;
  logic [pacb_pkg::LEN_ACC_W-1:0] len_acc_q;
  logic signed [W-1:0]  box_n_q, box_s_q, box_e_q, box_w_q;

  logic [DW-1:0]  dx_mag_q, dy_mag_q, sx_mag_q, sy_mag_q;
  logic           sx_neg_q, sy_neg_q, area_neg_q;
  logic [ABW-1:0] ab_a_q, ab_b_q;
  logic [KW-1:0]  k_q;
  logic [63:0]    lo_q;
  logic [LEN_W-1:0] len_q;

  logic [LEN_W-1:0] mul_a_q;
  logic [BPW-1:0]   mul_b_q;
  logic [PX-1:0]    prod_q;
  logic [MCW-1:0]   mcnt_q;
  logic [LEN_W+CH-1:0] pp;

  logic signed [W-1:0] cx_q, cy_q;
  logic                cvalid_q;

  logic                 out_valid_q, status_q, cv_out_q;
  logic signed [AW-1:0] area_out_q;
  logic signed [W-1:0]  bn_out_q, bs_out_q, be_out_q, bw_out_q, cx_out_q, cy_out_q;

  logic signed [DW-1:0] dx, dy, sx, sy;
  logic [DW-1:0]        dxm, dym, sxm, sym;
  logic [ABW-1:0]       ab_or;
  logic                 norm_more;
  logic [64:0]          lo_sum;
  logic [SUMW-1:0]      len_sum;
  logic [AW-1:0]        wx_mag, wy_mag;

  logic sq_start, sq_busy, dv_start, dv_busy, out_load, out_free;
  logic [pacb_pkg::SQRT_OUT_W-1:0] sq_root;
  logic [AW-1:0]                   dv_quo;
  logic [AW-1:0]                   dv_dividend;

  assign dx  = {q_x_i[W-1], q_x_i} - {prev_x_q[W-1], prev_x_q};
  assign dy  = {q_y_i[W-1], q_y_i} - {prev_y_q[W-1], prev_y_q};
  assign sx  = {q_x_i[W-1], q_x_i} + {prev_x_q[W-1], prev_x_q};
  assign sy  = {q_y_i[W-1], q_y_i} + {prev_y_q[W-1], prev_y_q};
  assign dxm = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign dym = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign sxm = sx[DW-1] ? DW'(-sx) : DW'(sx);
  assign sym = sy[DW-1] ? DW'(-sy) : DW'(sy);

  assign ab_or     = ab_a_q | ab_b_q;
  assign norm_more = |ab_or[ABW-1:32];
  assign lo_sum    = {1'b0, lo_q} + {1'b0, prod_q[63:0]};
  assign len_sum   = SUMW'(len_acc_q) + SUMW'(len_q);
  assign wx_mag    = wx_q[AW-1] ? AW'(-wx_q) : AW'(wx_q);
  assign wy_mag    = wy_q[AW-1] ? AW'(-wy_q) : AW'(wy_q);
  assign pp        = {{CH{1'b0}}, mul_a_q} * {{LEN_W{1'b0}}, mul_b_q[BPW-1 -: CH]};
  assign out_free  = !out_valid_q || out_ready_i;

  pacb_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i ({1'b0, lo_sum}),
    .busy_o     (sq_busy),
    .root_o     (sq_root)
  );

  assign dv_dividend = (state_q == pacb_pkg::ST_DIVX_LD) ? wx_mag : wy_mag;

  pacb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_dividend),
    .divisor_i  (len_acc_q),
    .busy_o     (dv_busy),
    .quotient_o (dv_quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pacb_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_ctrl_i.op)
            pacb_pkg::OP_EMPTY:   state_d = pacb_pkg::ST_OUT;
            pacb_pkg::OP_OPEN:    state_d = q_ctrl_i.ends ? pacb_pkg::ST_FIN : pacb_pkg::ST_IDLE;
            pacb_pkg::OP_SEGMENT: state_d = pacb_pkg::ST_MUL_LOAD;
            default:              state_d = pacb_pkg::ST_IDLE;
          endcase
        end
      end
      pacb_pkg::ST_MUL_LOAD: state_d = pacb_pkg::ST_MUL;
      pacb_pkg::ST_MUL: begin
        if (mcnt_q == MCW'(1)) begin
          state_d = pacb_pkg::ST_MUL_DONE;
        end
      end
      pacb_pkg::ST_MUL_DONE: begin
        unique case (job_q)
          pacb_pkg::JOB_AREA: state_d = pacb_pkg::ST_NORM;
          pacb_pkg::JOB_B2:   state_d = pacb_pkg::ST_SQRT;
          pacb_pkg::JOB_WY:   state_d = ends_q ? pacb_pkg::ST_FIN : pacb_pkg::ST_IDLE;
          default:            state_d = pacb_pkg::ST_MUL_LOAD;
        endcase
      end
      pacb_pkg::ST_NORM: begin
        if (!norm_more) begin
          state_d = pacb_pkg::ST_MUL_LOAD;
        end
      end
      pacb_pkg::ST_SQRT: begin
        if (!sq_busy) begin
          state_d = pacb_pkg::ST_MUL_LOAD;
        end
      end
      pacb_pkg::ST_FIN: begin
        state_d = (len_acc_q == '0) ? pacb_pkg::ST_OUT : pacb_pkg::ST_DIVX_LD;
      end
      pacb_pkg::ST_DIVX_LD: state_d = pacb_pkg::ST_DIVX;
      pacb_pkg::ST_DIVX: begin
        if (!dv_busy) begin
          state_d = pacb_pkg::ST_DIVY_LD;
        end
      end
      pacb_pkg::ST_DIVY_LD: state_d = pacb_pkg::ST_DIVY;
      pacb_pkg::ST_DIVY: begin
        if (!dv_busy) begin
          state_d = pacb_pkg::ST_OUT;
        end
      end
      pacb_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = pacb_pkg::ST_IDLE;
        end
      end
      default: state_d = pacb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = (state_q == pacb_pkg::ST_IDLE) && q_valid_i;
    sq_start = (state_q == pacb_pkg::ST_MUL_DONE) && (job_q == pacb_pkg::JOB_B2);
    dv_start = (state_q == pacb_pkg::ST_DIVX_LD) || (state_q == pacb_pkg::ST_DIVY_LD);
    out_load = (state_q == pacb_pkg::ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pacb_pkg::ST_IDLE;
      job_q       <= pacb_pkg::JOB_AREA;
      ends_q      <= 1'b0;
      res_empty_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      cur_rev_q   <= 1'b0;
      area_open_q <= 1'b0;
      area_q      <= '0;
      wx_q        <= '0;
      wy_q        <= '0;
      len_acc_q   <= '0;
      box_n_q     <= C_MIN;
      box_s_q     <= C_MAX;
      box_e_q     <= C_MIN;
      box_w_q     <= C_MAX;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_ctrl_i.load_north && !area_open_q) box_n_q <= cfg_wdata_i;
      if (cfg_ctrl_i.load_south && !area_open_q) box_s_q <= cfg_wdata_i;
      if (cfg_ctrl_i.load_east  && !area_open_q) box_e_q <= cfg_wdata_i;
      if (cfg_ctrl_i.load_west  && !area_open_q) box_w_q <= cfg_wdata_i;

      if (q_pop_o) begin
        ends_q      <= q_ctrl_i.ends;
        res_empty_q <= (q_ctrl_i.op == pacb_pkg::OP_EMPTY);
        if (q_ctrl_i.op != pacb_pkg::OP_EMPTY) begin
          prev_x_q    <= q_x_i;
          prev_y_q    <= q_y_i;
          area_open_q <= 1'b1;
        end
        if (q_ctrl_i.op == pacb_pkg::OP_OPEN) begin
          cur_rev_q <= q_ctrl_i.rev;
        end
        if (q_ctrl_i.op == pacb_pkg::OP_SEGMENT) begin
          job_q <= pacb_pkg::JOB_AREA;
          if (prev_y_q > box_n_q) box_n_q <= prev_y_q;
          if (prev_y_q < box_s_q) box_s_q <= prev_y_q;
          if (prev_x_q > box_e_q) box_e_q <= prev_x_q;
          if (prev_x_q < box_w_q) box_w_q <= prev_x_q;
        end
      end

      if (state_q == pacb_pkg::ST_MUL_LOAD) begin
        mcnt_q <= MCW'(NCH);
      end else if (state_q == pacb_pkg::ST_MUL) begin
        mcnt_q <= mcnt_q - MCW'(1);
      end

      if (state_q == pacb_pkg::ST_MUL_DONE) begin
        unique case (job_q)
          pacb_pkg::JOB_AREA: area_q <= sat_add(area_q, half_term(prod_q, area_neg_q));
          pacb_pkg::JOB_A2:   job_q  <= pacb_pkg::JOB_B2;
          pacb_pkg::JOB_B2:   job_q  <= pacb_pkg::JOB_WX;
          pacb_pkg::JOB_WX: begin
            wx_q  <= sat_add(wx_q, half_term(prod_q, sx_neg_q));
            job_q <= pacb_pkg::JOB_WY;
          end
          pacb_pkg::JOB_WY: begin
            wy_q <= sat_add(wy_q, half_term(prod_q, sy_neg_q));
            if (len_sum > SUMW'({pacb_pkg::LEN_ACC_W{1'b1}})) begin
              len_acc_q <= '1;
            end else begin
              len_acc_q <= len_sum[pacb_pkg::LEN_ACC_W-1:0];
            end
          end
          default: job_q <= pacb_pkg::JOB_AREA;
        endcase
      end

      if ((state_q == pacb_pkg::ST_NORM) && !norm_more) begin
        job_q <= pacb_pkg::JOB_A2;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
        prev_x_q    <= '0;
        prev_y_q    <= '0;
        cur_rev_q   <= 1'b0;
        area_open_q <= 1'b0;
        area_q      <= '0;
        wx_q        <= '0;
        wy_q        <= '0;
        len_acc_q   <= '0;
        box_n_q     <= init_north_i;
        box_s_q     <= init_south_i;
        box_e_q     <= init_east_i;
        box_w_q     <= init_west_i;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && (q_ctrl_i.op == pacb_pkg::OP_SEGMENT)) begin
      dx_mag_q   <= dxm;
      dy_mag_q   <= dym;
      sx_mag_q   <= sxm;
      sy_mag_q   <= sym;
      sx_neg_q   <= sx[DW-1];
      sy_neg_q   <= sy[DW-1];
      area_neg_q <= (dx[DW-1] ^ sy[DW-1]) ^ cur_rev_q;
    end

    if (state_q == pacb_pkg::ST_MUL_LOAD) begin
      prod_q <= '0;
      unique case (job_q)
        pacb_pkg::JOB_AREA: begin
          mul_a_q <= LEN_W'(dx_mag_q);
          mul_b_q <= BPW'(sy_mag_q);
        end
        pacb_pkg::JOB_A2: begin
          mul_a_q <= LEN_W'(ab_a_q);
          mul_b_q <= BPW'(ab_a_q);
        end
        pacb_pkg::JOB_B2: begin
          mul_a_q <= LEN_W'(ab_b_q);
          mul_b_q <= BPW'(ab_b_q);
        end
        pacb_pkg::JOB_WX: begin
          mul_a_q <= len_q;
          mul_b_q <= BPW'(sx_mag_q);
        end
        default: begin
          mul_a_q <= len_q;
          mul_b_q <= BPW'(sy_mag_q);
        end
      endcase
    end else if (state_q == pacb_pkg::ST_MUL) begin
      prod_q  <= (prod_q << CH) + PX'(pp);
      mul_b_q <= mul_b_q << CH;
    end

    if ((state_q == pacb_pkg::ST_MUL_DONE) && (job_q == pacb_pkg::JOB_AREA)) begin
      ab_a_q <= ABW'(dx_mag_q);
      ab_b_q <= ABW'(dy_mag_q);
      k_q    <= '0;
    end else if ((state_q == pacb_pkg::ST_NORM) && norm_more) begin
      ab_a_q <= ab_a_q >> 1;
      ab_b_q <= ab_b_q >> 1;
      k_q    <= k_q + KW'(1);
    end

    if ((state_q == pacb_pkg::ST_MUL_DONE) && (job_q == pacb_pkg::JOB_A2)) begin
      lo_q <= prod_q[63:0];
    end

    if ((state_q == pacb_pkg::ST_SQRT) && !sq_busy) begin
      len_q <= LEN_W'(RW2'(sq_root) << k_q);
    end

    if (state_q == pacb_pkg::ST_FIN) begin
      cvalid_q <= (len_acc_q != '0);
      cx_q     <= '0;
      cy_q     <= '0;
    end
    if ((state_q == pacb_pkg::ST_DIVX) && !dv_busy) begin
      cx_q <= clamp(dv_quo, wx_q[AW-1]);
    end
    if ((state_q == pacb_pkg::ST_DIVY) && !dv_busy) begin
      cy_q <= clamp(dv_quo, wy_q[AW-1]);
    end

    if (out_load) begin
      status_q   <= res_empty_q;
      area_out_q <= res_empty_q ? '0 : area_q;
      bn_out_q   <= res_empty_q ? '0 : box_n_q;
      bs_out_q   <= res_empty_q ? '0 : box_s_q;
      be_out_q   <= res_empty_q ? '0 : box_e_q;
      bw_out_q   <= res_empty_q ? '0 : box_w_q;
      cx_out_q   <= res_empty_q ? '0 : cx_q;
      cy_out_q   <= res_empty_q ? '0 : cy_q;
      cv_out_q   <= res_empty_q ? 1'b0 : cvalid_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign signed_area_o    = area_out_q;
  assign bound_north_o    = bn_out_q;
  assign bound_south_o    = bs_out_q;
  assign bound_east_o     = be_out_q;
  assign bound_west_o     = bw_out_q;
  assign centroid_x_o     = cx_out_q;
  assign centroid_y_o     = cy_out_q;
  assign centroid_valid_o = cv_out_q;

endmodule

`default_nettype wire

/* rtl/core/polygon_area_centroid_bounds.sv */
// ----------------------------------------------------------------------------
// polygon_area_centroid_bounds
// Signed area, length-weighted boundary centroid and bounding box of an area.
// ----------------------------------------------------------------------------
// Vertex items enter a two-entry queue and are processed one at a time. A
// vertex that closes a segment runs the 16-bit-per-cycle multiplier for the
// area, square and weight products and the 33-step square root; where a
// coordinate difference is wider than 32 bits, the differences are first
// scaled down. The last vertex of an area runs the two 64-step centroid
// divisions when the boundary length is not zero, and the result then waits
// in an output register while later items are already taken in.
`default_nettype none

module polygon_area_centroid_bounds #(
  parameter int COORD_WIDTH = 32
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire signed [COORD_WIDTH-1:0]           coord_x_i,
  input  wire signed [COORD_WIDTH-1:0]           coord_y_i,
  input  wire                                    starts_line_i,
  input  wire                                    line_reversed_i,
  input  wire                                    ends_area_i,
  input  wire                                    empty_area_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic                                   status_o,
  output logic signed [63:0]                     signed_area_o,
  output logic signed [COORD_WIDTH-1:0]          bound_north_o,
  output logic signed [COORD_WIDTH-1:0]          bound_south_o,
  output logic signed [COORD_WIDTH-1:0]          bound_east_o,
  output logic signed [COORD_WIDTH-1:0]          bound_west_o,
  output logic signed [COORD_WIDTH-1:0]          centroid_x_o,
  output logic signed [COORD_WIDTH-1:0]          centroid_y_o,
  output logic                                   centroid_valid_o,
  input  wire                                    cfg_we_i,
  input  wire [pacb_pkg::CFG_INDEX_W-1:0]        cfg_index_i,
  input  wire [COORD_WIDTH-1:0]                  cfg_wdata_i
);

  localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [COORD_WIDTH-1:0] init_n_q, init_s_q, init_e_q, init_w_q;
  pacb_pkg::cfg_ctrl_t           cfg_ctrl;
  logic                          q_valid, q_pop;
  logic signed [COORD_WIDTH-1:0] q_x, q_y;
  pacb_pkg::item_ctrl_t          q_ctrl;

  always_comb begin
    cfg_ctrl.load_north = cfg_we_i && (cfg_index_i == pacb_pkg::REG_NORTH);
    cfg_ctrl.load_south = cfg_we_i && (cfg_index_i == pacb_pkg::REG_SOUTH);
    cfg_ctrl.load_east  = cfg_we_i && (cfg_index_i == pacb_pkg::REG_EAST);
    cfg_ctrl.load_west  = cfg_we_i && (cfg_index_i == pacb_pkg::REG_WEST);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_n_q <= C_MIN;
      init_s_q <= C_MAX;
      init_e_q <= C_MIN;
      init_w_q <= C_MAX;
    end else begin
      if (cfg_ctrl.load_north) init_n_q <= cfg_wdata_i;
      if (cfg_ctrl.load_south) init_s_q <= cfg_wdata_i;
      if (cfg_ctrl.load_east)  init_e_q <= cfg_wdata_i;
      if (cfg_ctrl.load_west)  init_w_q <= cfg_wdata_i;
    end
  end

  pacb_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .starts_line_i   (starts_line_i),
    .line_reversed_i (line_reversed_i),
    .ends_area_i     (ends_area_i),
    .empty_area_i    (empty_area_i),
    .q_valid_o       (q_valid),
    .q_pop_i         (q_pop),
    .q_x_o           (q_x),
    .q_y_o           (q_y),
    .q_ctrl_o        (q_ctrl)
  );

  pacb_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_pop_o          (q_pop),
    .q_x_i            (q_x),
    .q_y_i            (q_y),
    .q_ctrl_i         (q_ctrl),
    .cfg_ctrl_i       (cfg_ctrl),
    .cfg_wdata_i      (cfg_wdata_i),
    .init_north_i     (init_n_q),
    .init_south_i     (init_s_q),
    .init_east_i      (init_e_q),
    .init_west_i      (init_w_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .signed_area_o    (signed_area_o),
    .bound_north_o    (bound_north_o),
    .bound_south_o    (bound_south_o),
    .bound_east_o     (bound_east_o),
    .bound_west_o     (bound_west_o),
    .centroid_x_o     (centroid_x_o),
    .centroid_y_o     (centroid_y_o),
    .centroid_valid_o (centroid_valid_o)
  );

  // An empty area reports nothing but its status.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> (signed_area_o == '0) && !centroid_valid_o)
    else $error("empty area item carries data");

  a_centroid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !centroid_valid_o |-> (centroid_x_o == '0) && (centroid_y_o == '0))
    else $error("invalid centroid is not zero");

  a_full_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("input stalled with an empty queue");

endmodule

`default_nettype wire
